/* rtl/core/cht_pkg.sv */
package cht_pkg;

    // Table geometry.
    localparam int NUM_BUCKETS  = 16;
    localparam int BUCKET_SLOTS = 4;
    localparam int TOTAL_SLOTS  = NUM_BUCKETS * BUCKET_SLOTS;

    // Field widths fixed by the interface.
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 64;
    localparam int OP_W    = 2;
    localparam int BSEL_W  = 4;
    localparam int SSEL_W  = 2;
    localparam int STAT_W  = 2;
    localparam int ICNT_W  = 7;

    // Derived widths.
    localparam int BUCKET_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SLOT_W   = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int FILL_W   = $clog2(BUCKET_SLOTS + 1);
    localparam int COUNT_W  = $clog2(TOTAL_SLOTS + 1);
    localparam int ROW_W    = BUCKET_SLOTS * KEY_W;

    typedef logic [KEY_W-1:0] word_t;
    typedef word_t [BUCKET_SLOTS-1:0] row_t;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_EVAL
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } cht_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } cht_status_t;

endpackage

/* rtl/core/cht_ram.sv */
module cht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/cht_ctrl.sv */
module cht_ctrl import cht_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  cht_status_t status,
    output cht_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTRL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            CTRL_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = CTRL_EVAL;
                end
            end
            CTRL_EVAL: begin
                // Wait until the result register can take the answer.
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = CTRL_IDLE;
                end
            end
            default: begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/cht_datapath.sv */
module cht_datapath import cht_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cht_cmd_t            cmd,
    output cht_status_t         status,
    input  logic [OP_W-1:0]     s_op,
    input  logic [KEY_W-1:0]    s_key,
    input  logic [VALUE_W-1:0]  s_new_value,
    input  logic [BSEL_W-1:0]   s_bucket_sel,
    input  logic [SSEL_W-1:0]   s_slot_sel,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic [VALUE_W-1:0]  m_out_value,
    output logic [KEY_W-1:0]    m_out_key,
    output logic [STAT_W-1:0]   m_status,
    output logic [ICNT_W-1:0]   m_item_count
);

    // Captured request.
    op_t                  op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   nv_reg;
    logic [SSEL_W-1:0]    ssel_reg;
    logic                 bsel_ok_reg;
    logic [BUCKET_W-1:0]  bucket_reg;

    // Table bookkeeping.
    logic [FILL_W-1:0]    fill_reg [NUM_BUCKETS];
    logic [COUNT_W-1:0]   total_reg;

    // Result register.
    logic                 m_valid_reg;
    logic                 hit_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [KEY_W-1:0]     okey_reg;
    status_t              stat_reg;
    logic [ICNT_W-1:0]    icnt_reg;

    logic [BUCKET_W-1:0]  rd_bucket;
    row_t                 key_row;
    row_t                 val_row;
    row_t                 key_row_next;
    row_t                 val_row_next;
    logic                 row_we;

    logic [FILL_W-1:0]    fill_cur;
    logic [FILL_W-1:0]    fill_next;
    logic [COUNT_W-1:0]   total_next;
    logic                 found;
    logic [SLOT_W-1:0]    found_idx;
    logic [SLOT_W-1:0]    last_idx;
    logic [SLOT_W-1:0]    app_idx;
    logic [SLOT_W-1:0]    read_idx;
    logic                 hit_next;
    logic [VALUE_W-1:0]   value_next;
    logic [KEY_W-1:0]     okey_next;
    status_t              stat_next;

    // The bucket row is read at the accepting edge.
    assign rd_bucket = (op_t'(s_op) == OP_READ) ? BUCKET_W'(s_bucket_sel)
                                                 : s_key[BUCKET_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= op_t'(s_op);
            key_reg     <= s_key;
            nv_reg      <= s_new_value;
            ssel_reg    <= s_slot_sel;
            bsel_ok_reg <= (32'(s_bucket_sel) < NUM_BUCKETS);
            bucket_reg  <= rd_bucket;
        end
    end

    // Key and value slot memories, one row per bucket.
    cht_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BUCKETS)) u_key_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (bucket_reg),
        .wdata (key_row_next),
        .re    (cmd.capture),
        .raddr (rd_bucket),
        .rdata (key_row)
    );

    cht_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BUCKETS)) u_val_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (bucket_reg),
        .wdata (val_row_next),
        .re    (cmd.capture),
        .raddr (rd_bucket),
        .rdata (val_row)
    );

    assign fill_cur = fill_reg[bucket_reg];
    assign last_idx = SLOT_W'(fill_cur - FILL_W'(1));
    assign app_idx  = SLOT_W'(fill_cur);
    assign read_idx = SLOT_W'(ssel_reg);

    // Compare the key against every occupied slot of the bucket.
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = 0; i < BUCKET_SLOTS; i++) begin
            if (!found && (32'(i) < 32'(fill_cur)) && key_row[i] == key_reg) begin
                found     = 1'b1;
                found_idx = SLOT_W'(i);
            end
        end
    end

    // Operation result and row update.
    always_comb begin
        key_row_next = key_row;
        val_row_next = val_row;
        row_we       = 1'b0;
        fill_next    = fill_cur;
        total_next   = total_reg;
        hit_next     = 1'b0;
        value_next   = '0;
        okey_next    = '0;
        stat_next    = ST_OK;
        unique case (op_reg)
            OP_LOOKUP: begin
                if (found) begin
                    hit_next   = 1'b1;
                    value_next = val_row[found_idx];
                end else begin
                    stat_next = ST_MISS;
                end
            end
            OP_INSERT: begin
                if (found) begin
                    // Replace the value and return the old one.
                    hit_next                = 1'b1;
                    value_next              = val_row[found_idx];
                    val_row_next[found_idx] = nv_reg;
                    row_we                  = 1'b1;
                end else if (32'(fill_cur) >= BUCKET_SLOTS) begin
                    stat_next = ST_FULL;
                end else begin
                    // Append behind the last occupied slot.
                    key_row_next[app_idx] = key_reg;
                    val_row_next[app_idx] = nv_reg;
                    row_we                = 1'b1;
                    fill_next             = fill_cur + FILL_W'(1);
                    total_next            = total_reg + COUNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (found) begin
                    // The bucket's last entry moves into the freed slot.
                    hit_next                = 1'b1;
                    value_next              = val_row[found_idx];
                    key_row_next[found_idx] = key_row[last_idx];
                    val_row_next[found_idx] = val_row[last_idx];
                    row_we                  = 1'b1;
                    fill_next               = fill_cur - FILL_W'(1);
                    total_next              = total_reg - COUNT_W'(1);
                end else begin
                    stat_next = ST_MISS;
                end
            end
            OP_READ: begin
                if (bsel_ok_reg && (32'(ssel_reg) < 32'(fill_cur))) begin
                    hit_next   = 1'b1;
                    value_next = val_row[read_idx];
                    okey_next  = key_row[read_idx];
                end else begin
                    stat_next = ST_MISS;
                end
            end
            default: begin
                stat_next = ST_MISS;
            end
        endcase
        row_we = row_we && cmd.commit;
    end

    // Fill counts and entry total.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                fill_reg[b] <= '0;
            end
            total_reg <= '0;
        end else if (cmd.commit) begin
            fill_reg[bucket_reg] <= fill_next;
            total_reg            <= total_next;
        end
    end

    // Result register: loads on commit, empties on a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            hit_reg   <= hit_next;
            value_reg <= value_next;
            okey_reg  <= okey_next;
            stat_reg  <= stat_next;
            icnt_reg  <= ICNT_W'(total_next);
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_hit        = hit_reg;
    assign m_out_value  = value_reg;
    assign m_out_key    = okey_reg;
    assign m_status     = stat_reg;
    assign m_item_count = icnt_reg;

endmodule

/* rtl/core/chained_hash_table_engine.sv */
// Separate-chaining hash table of 64-bit keys and values: 16 buckets of 4 slots,
// bucket chosen by the key's low bits (by s_bucket_sel for a read). The accept
// cycle reads the whole bucket row from the key and value slot memories, and
// the evaluate state compares all slots at once, writes the row back and loads
// the result register. The next operation is accepted only after that, so
// operations never overlap; a result left waiting on m_ready holds the evaluate
// state until the result register frees. Fill counts live in flip-flops cleared
// by reset, so the table is usable right after reset with no clearing pass.
// Insert into a full bucket is refused with status full; there is no rehashing.
module chained_hash_table_engine import cht_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [KEY_W-1:0]    s_key,
    input  logic [VALUE_W-1:0]  s_new_value,
    input  logic [BSEL_W-1:0]   s_bucket_sel,
    input  logic [SSEL_W-1:0]   s_slot_sel,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic [VALUE_W-1:0]  m_out_value,
    output logic [KEY_W-1:0]    m_out_key,
    output logic [STAT_W-1:0]   m_status,
    output logic [ICNT_W-1:0]   m_item_count
);

    cht_cmd_t    cmd;
    cht_status_t status;

    // Operation sequencing.
    cht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Slot memories, compare logic and result register.
    cht_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_op         (s_op),
        .s_key        (s_key),
        .s_new_value  (s_new_value),
        .s_bucket_sel (s_bucket_sel),
        .s_slot_sel   (s_slot_sel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_out_value  (m_out_value),
        .m_out_key    (m_out_key),
        .m_status     (m_status),
        .m_item_count (m_item_count)
    );

endmodule

/* rtl/core/cht_checker.sv */
module cht_checker import cht_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [OP_W-1:0]     s_op,
    input logic [KEY_W-1:0]    s_key,
    input logic [VALUE_W-1:0]  s_new_value,
    input logic [BSEL_W-1:0]   s_bucket_sel,
    input logic [SSEL_W-1:0]   s_slot_sel,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_hit,
    input logic [VALUE_W-1:0]  m_out_value,
    input logic [KEY_W-1:0]    m_out_key,
    input logic [STAT_W-1:0]   m_status,
    input logic [ICNT_W-1:0]   m_item_count
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value) && $stable(m_status))
        else $error("result changed while stalled");

    // One operation at a time: no transfer in the cycle after an accepted one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken during an operation");

    // A hit always reports status ok.
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_status == ST_OK)
        else $error("hit with nonzero status");

    // A miss or refusal carries a zero value.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_out_value == '0 && m_out_key == '0)
        else $error("miss with nonzero payload");

    // The entry count never exceeds the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_item_count) <= TOTAL_SLOTS)
        else $error("item count beyond table size");

endmodule

bind chained_hash_table_engine cht_checker u_cht_checker (.*);

/* tb/sv/chained_hash_table_engine_test.sv */
`timescale 1ns / 100ps

module chained_hash_table_engine_test;
    import cht_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 250000;
    localparam int POOL_DEPTH  = 6;
    localparam int HOLD_CYCLES = 300;

    // One expected table result, field for field as the block returns it.
    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] value;
        logic [KEY_W-1:0]   key;
        status_t            status;
        logic [ICNT_W-1:0]  count;
    } table_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [OP_W-1:0]    s_op = OP_LOOKUP;
    logic [KEY_W-1:0]   s_key = '0;
    logic [VALUE_W-1:0] s_new_value = '0;
    logic [BSEL_W-1:0]  s_bucket_sel = '0;
    logic [SSEL_W-1:0]  s_slot_sel = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_hit;
    logic [VALUE_W-1:0] m_out_value;
    logic [KEY_W-1:0]   m_out_key;
    logic [STAT_W-1:0]  m_status;
    logic [ICNT_W-1:0]  m_item_count;

    // Shadow copy of the table contents.
    word_t tbl_keys [NUM_BUCKETS][BUCKET_SLOTS];
    word_t tbl_vals [NUM_BUCKETS][BUCKET_SLOTS];
    int    tbl_fill [NUM_BUCKETS];
    int    tbl_total;

    // Per-bucket key candidates; more candidates than slots so buckets overflow.
    word_t key_pool [NUM_BUCKETS][POOL_DEPTH];

    table_result_t pending_results[$];

    int  sender_idle_pct = 0;
    int  sink_stall_pct = 0;
    logic rx_hold = 1'b0;
    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  accepted_ops = 0;
    int  hit_total = 0;
    int  full_total = 0;
    int  peak_count = 0;
    int  input_stall_cycles = 0;

    chained_hash_table_engine DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_key        (s_key),
        .s_new_value  (s_new_value),
        .s_bucket_sel (s_bucket_sel),
        .s_slot_sel   (s_slot_sel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_out_value  (m_out_value),
        .m_out_key    (m_out_key),
        .m_status     (m_status),
        .m_item_count (m_item_count)
    );

    always #CLK_HALF aclk = ~aclk;

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result ready: random stalls, forced low during a hold-off.
    always @(posedge aclk) begin
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("Mismatch at cycle %0d on %s: got %h, expected %h.",
                 cycle_count, field, got, want);
    endtask

    // Apply one operation to the shadow table and return what the block should report.
    function automatic table_result_t apply_table_op(input op_t op, input word_t key,
                                                     input word_t nv,
                                                     input logic [BSEL_W-1:0] bsel,
                                                     input logic [SSEL_W-1:0] ssel);
        table_result_t r;
        int b;
        int s;
        int last;
        r.hit    = 1'b0;
        r.value  = '0;
        r.key    = '0;
        r.status = ST_OK;
        b = int'(key[BUCKET_W-1:0]);
        s = -1;
        for (int i = tbl_fill[b] - 1; i >= 0; i--) begin
            if (tbl_keys[b][i] == key) s = i;
        end
        case (op)
            OP_LOOKUP: begin
                if (s >= 0) begin
                    r.hit   = 1'b1;
                    r.value = tbl_vals[b][s];
                end else begin
                    r.status = ST_MISS;
                end
            end
            OP_INSERT: begin
                if (s >= 0) begin
                    r.hit   = 1'b1;
                    r.value = tbl_vals[b][s];
                    tbl_vals[b][s] = nv;
                end else if (tbl_fill[b] >= BUCKET_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_keys[b][tbl_fill[b]] = key;
                    tbl_vals[b][tbl_fill[b]] = nv;
                    tbl_fill[b]++;
                    tbl_total++;
                end
            end
            OP_REMOVE: begin
                if (s >= 0) begin
                    // The bucket's last entry moves into the freed slot.
                    last    = tbl_fill[b] - 1;
                    r.hit   = 1'b1;
                    r.value = tbl_vals[b][s];
                    tbl_keys[b][s] = tbl_keys[b][last];
                    tbl_vals[b][s] = tbl_vals[b][last];
                    tbl_fill[b]--;
                    tbl_total--;
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: begin
                if (int'(ssel) < tbl_fill[bsel]) begin
                    r.hit   = 1'b1;
                    r.value = tbl_vals[bsel][ssel];
                    r.key   = tbl_keys[bsel][ssel];
                end else begin
                    r.status = ST_MISS;
                end
            end
        endcase
        r.count = ICNT_W'(tbl_total);
        return r;
    endfunction

    // Offer one operation, wait for its transfer, predict it, then maybe go idle.
    task automatic send_table_op(input op_t op, input word_t key, input word_t nv,
                                 input logic [BSEL_W-1:0] bsel,
                                 input logic [SSEL_W-1:0] ssel);
        table_result_t r;
        bit idled;
        s_valid      <= 1'b1;
        s_op         <= op;
        s_key        <= key;
        s_new_value  <= nv;
        s_bucket_sel <= bsel;
        s_slot_sel   <= ssel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = apply_table_op(op, key, nv, bsel, ssel);
        pending_results.push_back(r);
        accepted_ops++;
        if (r.hit) hit_total++;
        if (r.status == ST_FULL) full_total++;
        if (tbl_total > peak_count) peak_count = tbl_total;
        idled = 1'b0;
        while ($urandom_range(99) < sender_idle_pct) begin
            if (!idled) s_valid <= 1'b0;
            idled = 1'b1;
            @(posedge aclk);
        end
    endtask

    // Result check: every transfer is compared with the oldest expectation.
    always @(posedge aclk) begin : result_check
        table_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_out_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_hit !== want.hit)
                    report_mismatch("hit", 64'(m_hit), 64'(want.hit));
                if (m_out_value !== want.value)
                    report_mismatch("out_value", m_out_value, want.value);
                if (m_out_key !== want.key) report_mismatch("out_key", m_out_key, want.key);
                if (m_status !== want.status)
                    report_mismatch("status", 64'(m_status), 64'(want.status));
                if (m_item_count !== want.count)
                    report_mismatch("item_count", 64'(m_item_count), 64'(want.count));
            end
        end
    end

    // Mostly keys from the bucket pools, sometimes an arbitrary key.
    function automatic word_t pick_key();
        if ($urandom_range(99) < 85) begin
            return key_pool[$urandom_range(NUM_BUCKETS - 1)][$urandom_range(POOL_DEPTH - 1)];
        end
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_ops(input int count, input int insert_pct);
        int sel;
        op_t op;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 20) op = OP_LOOKUP;
            else if (sel < 40) op = OP_READ;
            else if (sel < 40 + insert_pct) op = OP_INSERT;
            else op = OP_REMOVE;
            send_table_op(op, pick_key(), {$urandom(), $urandom()},
                          BSEL_W'($urandom_range(NUM_BUCKETS - 1)),
                          SSEL_W'($urandom_range(BUCKET_SLOTS - 1)));
        end
    endtask

    // Empty-table misses, replace, full bucket, remove with move, and slot reads.
    task automatic test_directed();
        send_table_op(OP_LOOKUP, 64'h0, 64'h0, 4'd0, 2'd0);
        send_table_op(OP_REMOVE, 64'h0, 64'h0, 4'd0, 2'd0);
        send_table_op(OP_READ,   64'h0, 64'h0, 4'd0, 2'd0);
        send_table_op(OP_INSERT, 64'h0, 64'hA5A5_A5A5_5A5A_5A5A, 4'd0, 2'd0);
        send_table_op(OP_INSERT, '1, 64'h0, 4'd15, 2'd3);
        send_table_op(OP_LOOKUP, 64'h0, '1, 4'd15, 2'd3);
        send_table_op(OP_LOOKUP, '1, 64'h0, 4'd0, 2'd0);
        send_table_op(OP_INSERT, 64'h0, '1, 4'd0, 2'd0);
        send_table_op(OP_INSERT, 64'h10, 64'h1, 4'd0, 2'd0);
        send_table_op(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000_0000_0000_0001, 4'd0, 2'd0);
        send_table_op(OP_INSERT, 64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF, 4'd0, 2'd0);
        send_table_op(OP_INSERT, 64'h20, 64'hDEAD_BEEF_0000_0001, 4'd0, 2'd0);
        send_table_op(OP_INSERT, 64'h10, 64'hFEDC_BA98_7654_3210, 4'd0, 2'd0);
        send_table_op(OP_READ,   '1, '1, 4'd0, 2'd3);
        send_table_op(OP_READ,   64'h0, 64'h0, 4'd15, 2'd0);
        send_table_op(OP_READ,   64'h0, 64'h0, 4'd15, 2'd3);
        send_table_op(OP_REMOVE, 64'h0, 64'h0, 4'd0, 2'd0);
        send_table_op(OP_READ,   64'h0, 64'h0, 4'd0, 2'd0);
        send_table_op(OP_READ,   64'h0, 64'h0, 4'd0, 2'd3);
        send_table_op(OP_REMOVE, 64'h8000_0000_0000_0000, 64'h0, 4'd0, 2'd0);
        send_table_op(OP_REMOVE, 64'h8000_0000_0000_0000, 64'h0, 4'd0, 2'd0);
        send_table_op(OP_LOOKUP, 64'h20, 64'h0, 4'd0, 2'd0);
        send_table_op(OP_REMOVE, '1, 64'h0, 4'd0, 2'd0);
        send_table_op(OP_LOOKUP, '1, 64'h0, 4'd0, 2'd0);
    endtask

    // Insert every pool key in shuffled order: all buckets fill, the rest are refused.
    task automatic test_fill_table();
        word_t order [NUM_BUCKETS * POOL_DEPTH];
        word_t tmp;
        int j;
        for (int n = 0; n < NUM_BUCKETS * POOL_DEPTH; n++) begin
            order[n] = key_pool[n / POOL_DEPTH][n % POOL_DEPTH];
        end
        for (int n = NUM_BUCKETS * POOL_DEPTH - 1; n > 0; n--) begin
            j = $urandom_range(n);
            tmp = order[n];
            order[n] = order[j];
            order[j] = tmp;
        end
        foreach (order[n]) begin
            send_table_op(OP_INSERT, order[n], {$urandom(), $urandom()},
                          BSEL_W'($urandom_range(NUM_BUCKETS - 1)),
                          SSEL_W'($urandom_range(BUCKET_SLOTS - 1)));
        end
    endtask

    task automatic test_no_idle();
        sender_idle_pct = 0;
        sink_stall_pct <= 0;
        random_ops(90, 30);
    endtask

    task automatic test_sender_idle();
        sender_idle_pct = 83;
        sink_stall_pct <= 0;
        random_ops(90, 15);
    endtask

    task automatic test_receiver_stall();
        sender_idle_pct = 0;
        sink_stall_pct <= 83;
        random_ops(90, 45);
    endtask

    task automatic test_both_idle();
        sender_idle_pct = 11;
        sink_stall_pct <= 11;
        random_ops(90, 30);
    endtask

    // Receiver holds off while the sender keeps offering, so the input backs up.
    task automatic test_receiver_holdoff();
        sender_idle_pct = 0;
        sink_stall_pct <= 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(posedge aclk);
                    if (s_valid && !s_ready) input_stall_cycles++;
                end
                rx_hold <= 1'b0;
            end
            random_ops(60, 30);
        join
    endtask

    initial begin
        for (int b = 0; b < NUM_BUCKETS; b++) begin
            tbl_fill[b] = 0;
            for (int i = 0; i < POOL_DEPTH; i++) begin
                key_pool[b][i] = {$urandom(), $urandom()};
                key_pool[b][i][BUCKET_W-1:0] = BUCKET_W'(b);
            end
        end
        tbl_total = 0;

        // Hold the synchronous reset, then release it.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_fill_table();
        test_no_idle();
        test_sender_idle();
        test_receiver_holdoff();
        test_receiver_stall();
        test_both_idle();

        // Stop offering right after the last transfer, then drain the outstanding results.
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Covered %0d operations with %0d hits and %0d full-bucket refusals.",
                 accepted_ops, hit_total, full_total);
        $display("Item count peaked at %0d; the hold-off stalled the input for %0d cycles.",
                 peak_count, input_stall_cycles);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches found.", mismatch_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* chained_hash_table_engine.f */
rtl/core/cht_pkg.sv
rtl/core/cht_ram.sv
rtl/core/cht_ctrl.sv
rtl/core/cht_datapath.sv
rtl/core/chained_hash_table_engine.sv
rtl/core/cht_checker.sv
tb/sv/chained_hash_table_engine_test.sv
